>>> design/spow_pkg.sv
// ----------------------------------------------------------------------------
// spow_pkg
// Shared types, constants and round functions for the proof-of-work search.
// ----------------------------------------------------------------------------
package spow_pkg;

  localparam int unsigned ProofW = 64;
  localparam int unsigned DiffW  = 7;
  localparam int unsigned StatW  = 2;
  localparam int unsigned Digits = 20;

  localparam logic [StatW-1:0] StatFound   = 2'd0;
  localparam logic [StatW-1:0] StatBadDiff = 2'd1;
  localparam logic [StatW-1:0] StatExhaust = 2'd2;

  localparam logic [7:0] AsciiZero = 8'h30;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // latch previous proof, clear candidate
    logic conv_init; // start decimal conversion of both values
    logic conv_step; // head or tail half of one digit for each value
    logic pack;      // assemble the padded block
    logic hash_init; // load working vars
    logic round;     // one compression round
    logic finish;    // add initial hash
    logic next_cand; // candidate + 1
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic rounds_done;
    logic hit;
    logic cand_last;
  } stat_t;

  typedef logic [31:0] word_t;

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> design/sha256_proof_of_work_search.sv
// Per candidate: decimal conversion (up to 20 digits each), pack, 64 rounds, finish, check.
// A bad difficulty offers its result word in the cycle after the request word is taken.
// One request at a time; the round unit is shared by all rounds.
// rst_ni clears the sequencer, candidate counter and difficulty (to 4).
// Result word is held until out_stall is low.
// ----------------------------------------------------------------------------
// sha256_proof_of_work_search
// Top level: difficulty register, sequencer and hash datapath.
// ----------------------------------------------------------------------------
module sha256_proof_of_work_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] previous_proof_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] found_proof_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  logic [6:0] diff_q;
  spow_pkg::cmd_t  cmd;
  spow_pkg::stat_t stat;
  logic [63:0] cand;
  logic take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) diff_q <= 7'd4;
    else if (cfg_valid && cfg_ready) diff_q <= cfg_data;
  end

  spow_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_stall, .out_valid,
    .difficulty_i(diff_q), .stat_i(stat), .cmd_o(cmd), .status_o, .take_cand_o(take)
  );

  spow_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .prev_i(previous_proof_i),
    .difficulty_i(diff_q), .stat_o(stat), .cand_o(cand)
  );

  assign found_proof_o = take ? cand : 64'd0;

  a_found_nonzero_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status_o != spow_pkg::StatFound |-> found_proof_o == 64'd0)
    else $error("non-found result carries a proof");
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> in_stall)
    else $error("input open while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(status_o))
    else $error("result changed under stall");

endmodule

>>> design/spow_ctrl.sv
// ----------------------------------------------------------------------------
// spow_ctrl
// Sequencer: handshakes, difficulty check, per-candidate phase stepping.
// ----------------------------------------------------------------------------
module spow_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          out_stall,
  output logic                          out_valid,
  input  logic [spow_pkg::DiffW-1:0]    difficulty_i,
  input  spow_pkg::stat_t               stat_i,
  output spow_pkg::cmd_t                cmd_o,
  output logic [spow_pkg::StatW-1:0]    status_o,
  output logic                          take_cand_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CONV = 6'b000010,
    S_PACK = 6'b000100,
    S_HASH = 6'b001000,
    S_EVAL = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [spow_pkg::StatW-1:0] status_q, status_d;
  logic take_q, take_d;
  logic accept, bad_diff;

  assign in_stall  = (state_q != S_IDLE);
  assign out_valid = (state_q == S_OUT);
  assign accept    = in_valid && !in_stall;
  assign bad_diff  = (difficulty_i == '0) || (difficulty_i > spow_pkg::DiffW'(64));
  assign status_o  = status_q;
  assign take_cand_o = take_q;

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    take_d   = take_q;
    cmd_o    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          if (bad_diff) begin
            status_d = spow_pkg::StatBadDiff;
            take_d   = 1'b0;
            state_d  = S_OUT;
          end else begin
            state_d = S_CONV;
          end
        end
      end
      S_CONV: begin
        if (stat_i.conv_done) begin
          state_d = S_PACK;
        end else begin
          cmd_o.conv_step = 1'b1;
        end
      end
      S_PACK: begin
        cmd_o.pack = 1'b1;
        state_d = S_HASH;
      end
      S_HASH: begin
        cmd_o.round = 1'b1;
        if (stat_i.rounds_done) begin
          cmd_o.round  = 1'b0;
          cmd_o.finish = 1'b1;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat_i.hit) begin
          status_d = spow_pkg::StatFound;
          take_d   = 1'b1;
          state_d  = S_OUT;
        end else if (stat_i.cand_last) begin
          status_d = spow_pkg::StatExhaust;
          take_d   = 1'b0;
          state_d  = S_OUT;
        end else begin
          cmd_o.next_cand = 1'b1;
          state_d = S_CONV;
        end
      end
      S_OUT: begin
        if (!out_stall) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    // restart conversion/hash setup whenever a candidate phase begins
    if (state_d == S_CONV && state_q != S_CONV) cmd_o.conv_init = 1'b1;
    if (state_d == S_HASH && state_q != S_HASH) cmd_o.hash_init = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= spow_pkg::StatFound;
      take_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      take_q   <= take_d;
    end
  end

endmodule

>>> design/spow_dp.sv
// ----------------------------------------------------------------------------
// spow_dp
// Datapath: digit extraction, block assembly, SHA-256 round unit, zero check.
// ----------------------------------------------------------------------------
module spow_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  spow_pkg::cmd_t               cmd_i,
  input  logic [spow_pkg::ProofW-1:0]  prev_i,
  input  logic [spow_pkg::DiffW-1:0]   difficulty_i,
  output spow_pkg::stat_t              stat_o,
  output logic [spow_pkg::ProofW-1:0]  cand_o
);

  localparam int unsigned ND = spow_pkg::Digits;

  logic [spow_pkg::ProofW-1:0] prev_q, cand_q;
  // values still under division by ten; each digit takes a head and a tail step
  logic [spow_pkg::ProofW-1:0] pr_q, cr_q;
  logic [spow_pkg::ProofW-1:0] pa_q, ca_q;
  logic       ph_q;
  logic [3:0] pdig_q [ND];
  logic [3:0] cdig_q [ND];
  logic [4:0] plen_q, clen_q;
  logic       pdone_q, cdone_q;
  logic [6:0] rnd_q;
  spow_pkg::word_t w_q [16];
  spow_pkg::word_t v_q [8];
  spow_pkg::word_t dg_q [8];

  // divide by ten with shifts and adds, split into a head and a tail step:
  // first half builds x*0.8 up to the 16-bit fold, second half finishes,
  // drops three bits and fixes the quotient with one compare
  function automatic logic [63:0] div10_head(input logic [63:0] x);
    logic [63:0] q;
    q = (x >> 1) + (x >> 2);
    q = q + (q >> 4);
    q = q + (q >> 8);
    div10_head = q + (q >> 16);
  endfunction

  // returns {quotient, digit}
  function automatic logic [67:0] div10_tail(input logic [63:0] x, input logic [63:0] a);
    logic [63:0] q, r;
    q = a + (a >> 32);
    q = q >> 3;
    r = x - ((q << 3) + (q << 1));
    if (r > 64'd9) div10_tail = {q + 64'd1, 4'(r - 64'd10)};
    else div10_tail = {q, 4'(r)};
  endfunction

  logic [63:0] pq, cq;
  logic [3:0]  pd, cd;
  assign {pq, pd} = div10_tail(pr_q, pa_q);
  assign {cq, cd} = div10_tail(cr_q, ca_q);

  // message bytes from digit lists
  logic [7:0] bytes [64];
  logic [5:0] tot;
  always_comb begin
    for (int i = 0; i < 64; i++) bytes[i] = 8'h00;
    tot = 6'(plen_q) + 6'(clen_q);
    for (int i = 0; i < ND; i++) begin
      if (5'(i) < plen_q) bytes[i] = spow_pkg::AsciiZero | 8'(pdig_q[plen_q - 5'(i) - 5'd1]);
    end
    for (int i = 0; i < ND; i++) begin
      if (5'(i) < clen_q)
        bytes[6'(plen_q) + 6'(i)] = spow_pkg::AsciiZero | 8'(cdig_q[clen_q - 5'(i) - 5'd1]);
    end
    bytes[tot] = 8'h80;
    bytes[62] = 8'({tot, 3'b000} >> 8);
    bytes[63] = 8'({tot, 3'b000});
  end

  spow_pkg::word_t s0, s1, wn, t1, t2, e, a;
  always_comb begin
    s0 = spow_pkg::rotr(w_q[1], 7) ^ spow_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = spow_pkg::rotr(w_q[14], 17) ^ spow_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wn = w_q[0] + s0 + w_q[9] + s1;
    e  = v_q[4];
    a  = v_q[0];
    t1 = v_q[7] + (spow_pkg::rotr(e, 6) ^ spow_pkg::rotr(e, 11) ^ spow_pkg::rotr(e, 25))
       + ((e & v_q[5]) ^ (~e & v_q[6])) + spow_pkg::RoundK[rnd_q[5:0]] + w_q[0];
    t2 = (spow_pkg::rotr(a, 2) ^ spow_pkg::rotr(a, 13) ^ spow_pkg::rotr(a, 22))
       + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // leading-zero check over 64 nibbles
  logic hit;
  always_comb begin
    logic [255:0] d;
    d = {dg_q[0], dg_q[1], dg_q[2], dg_q[3], dg_q[4], dg_q[5], dg_q[6], dg_q[7]};
    hit = 1'b1;
    for (int i = 0; i < 64; i++) begin
      if (7'(i) < difficulty_i && d[255 - 4*i -: 4] != 4'd0) hit = 1'b0;
    end
  end

  assign stat_o.conv_done   = pdone_q && cdone_q;
  assign stat_o.rounds_done = rnd_q[6];
  assign stat_o.hit         = hit;
  assign stat_o.cand_last   = (cand_q == {spow_pkg::ProofW{1'b1}} - 64'd1);
  assign cand_o = cand_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
      rnd_q  <= '0;
    end else begin
      if (cmd_i.load) cand_q <= '0;
      else if (cmd_i.next_cand) cand_q <= cand_q + 64'd1;
      if (cmd_i.hash_init) rnd_q <= '0;
      else if (cmd_i.round) rnd_q <= rnd_q + 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) prev_q <= prev_i;
    if (cmd_i.conv_init) begin
      pr_q <= cmd_i.load ? prev_i : prev_q;
      cr_q <= cmd_i.load ? 64'd0 : (cmd_i.next_cand ? cand_q + 64'd1 : cand_q);
      plen_q <= '0; clen_q <= '0; pdone_q <= 1'b0; cdone_q <= 1'b0;
      ph_q <= 1'b0;
    end else if (cmd_i.conv_step) begin
      ph_q <= ~ph_q;
      if (!ph_q) begin
        pa_q <= div10_head(pr_q);
        ca_q <= div10_head(cr_q);
      end else begin
        if (!pdone_q) begin
          pdig_q[plen_q] <= pd;
          plen_q <= plen_q + 5'd1;
          pr_q <= pq;
          pdone_q <= (pq == 64'd0);
        end
        if (!cdone_q) begin
          cdig_q[clen_q] <= cd;
          clen_q <= clen_q + 5'd1;
          cr_q <= cq;
          cdone_q <= (cq == 64'd0);
        end
      end
    end
    if (cmd_i.pack) begin
      for (int i = 0; i < 16; i++)
        w_q[i] <= {bytes[4*i], bytes[4*i+1], bytes[4*i+2], bytes[4*i+3]};
    end else if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wn;
    end
    if (cmd_i.hash_init) begin
      for (int i = 0; i < 8; i++) v_q[i] <= spow_pkg::InitH[i];
    end else if (cmd_i.round) begin
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4]; v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0]; v_q[0] <= t1 + t2;
    end
    if (cmd_i.finish) begin
      for (int i = 0; i < 8; i++) dg_q[i] <= spow_pkg::InitH[i] + v_q[i];
    end
  end

endmodule
